@@ rtl/oets_pkg.sv @@
// shared constants and types for the odd-even transposition sorter
`timescale 1ns / 1ps

package oets_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_SORT,
		CELL_DRAIN
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     odd_phase;
	} cell_cmd_t;

endpackage

@@ rtl/oets_cell.sv @@
// one sorter cell: holds an element, shifts on load and drain, compare-exchanges on sort
`timescale 1ns / 1ps

module oets_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  oets_pkg::cell_cmd_t cmd,
	input  logic               odd_pos,
	input  oets_pkg::data_t    left_value,
	input  logic               left_occ,
	input  oets_pkg::data_t    right_value,
	input  logic               right_occ,
	output oets_pkg::data_t    cell_value,
	output logic               cell_occ
);

	oets_pkg::data_t value_q;
	logic            occ_q;
	logic            lower_role;
	oets_pkg::data_t next_value;
	logic            next_occ;

	// lower element of its pair when position parity matches phase parity
	assign lower_role = (odd_pos == cmd.odd_phase);

	always_comb begin
		next_value = value_q;
		next_occ   = occ_q;
		unique case (cmd.op)
			oets_pkg::CELL_HOLD: begin
				next_value = value_q;
			end
			oets_pkg::CELL_LOAD: begin
				next_value = left_value;
				next_occ   = left_occ;
			end
			oets_pkg::CELL_SORT: begin
				if (lower_role) begin
					if (occ_q && right_occ && (value_q > right_value)) begin
						next_value = right_value;
					end
				end else begin
					if (occ_q && left_occ && (left_value > value_q)) begin
						next_value = left_value;
					end
				end
			end
			oets_pkg::CELL_DRAIN: begin
				next_value = right_value;
				next_occ   = right_occ;
			end
			default: begin
				next_value = value_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= next_occ;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= next_value;
	end

	assign cell_value = value_q;
	assign cell_occ   = occ_q;

endmodule

@@ rtl/odd_even_transposition_sort.sv @@
// top level: odd-even transposition sorter built from a row of cells
//
//  channel | direction | handshake           | payload
//  input   | in        | in_valid / in_stall | value, final_element
//  output  | out       | out_valid/out_stall | sorted_value, last_out
//
// a set of n elements takes n input transfers, then n sort phases (one phase
// per cycle across the cell row), then n output transfers
// input is stalled from the closing transfer until the last element is taken
// reset clears the control state and the cell occupancy bits; no clearing pass
// output stalls hold the cell row, so the set drains at the consumer's pace
`timescale 1ns / 1ps

module odd_even_transposition_sort (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [31:0]     value,
	input  logic                   final_element,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [31:0]     sorted_value,
	output logic                   last_out
);

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_SORT,
		ST_EMIT
	} state_t;

	localparam int N = oets_pkg::CAPACITY;

	state_t              state_q;
	oets_pkg::cnt_t      count_q;
	oets_pkg::cnt_t      phase_q;
	oets_pkg::cell_cmd_t cmd;
	logic                in_xfer;
	logic                out_xfer;

	oets_pkg::data_t cell_value [N];
	logic            cell_occ   [N];

	assign in_stall  = (state_q != ST_COLLECT);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = (state_q == ST_EMIT);
	assign out_xfer  = out_valid && !out_stall;

	always_comb begin
		cmd.odd_phase = phase_q[0];
		cmd.op        = oets_pkg::CELL_HOLD;
		if (in_xfer) begin
			cmd.op = oets_pkg::CELL_LOAD;
		end else if (state_q == ST_SORT) begin
			cmd.op = oets_pkg::CELL_SORT;
		end else if (out_xfer) begin
			cmd.op = oets_pkg::CELL_DRAIN;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		oets_pkg::data_t lv;
		logic            lo;
		oets_pkg::data_t rv;
		logic            ro;
		if (i == 0) begin : g_head
			assign lv = value;
			assign lo = in_xfer;
		end else begin : g_mid_l
			assign lv = cell_value[i-1];
			assign lo = cell_occ[i-1];
		end
		if (i == N - 1) begin : g_tail
			assign rv = cell_value[i];
			assign ro = 1'b0;
		end else begin : g_mid_r
			assign rv = cell_value[i+1];
			assign ro = cell_occ[i+1];
		end
		oets_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.odd_pos     (1'(i % 2)),
			.left_value  (lv),
			.left_occ    (lo),
			.right_value (rv),
			.right_occ   (ro),
			.cell_value  (cell_value[i]),
			.cell_occ    (cell_occ[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			count_q <= '0;
			phase_q <= '0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (in_xfer) begin
						count_q <= count_q + 1'b1;
						if (final_element ||
						    (count_q + 1'b1 == oets_pkg::cnt_t'(oets_pkg::CAPACITY))) begin
							phase_q <= '0;
							state_q <= ST_SORT;
						end
					end
				end
				ST_SORT: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q + 1'b1 == count_q) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_xfer) begin
						count_q <= count_q - 1'b1;
						if (count_q == oets_pkg::cnt_t'(1)) begin
							state_q <= ST_COLLECT;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	assign sorted_value = cell_value[0];
	assign last_out     = (count_q == oets_pkg::cnt_t'(1));

	a_out_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cell_occ[0])
		else $error("output shown from an empty head cell");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> (count_q < oets_pkg::cnt_t'(oets_pkg::CAPACITY)))
		else $error("input transfer into a full cell row");

	a_last_ends_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && last_out) |=> (!out_valid && (count_q == '0)))
		else $error("set did not close after its last element");

	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT) |-> (phase_q < count_q))
		else $error("sort phase ran past the element count");

endmodule
